### design/fddc_pkg.sv
`timescale 1ns / 1ps
// Package for the follow distance drive controller.
// Holds the direction, status and sequence phase codes, limits and the echo conversion.
package fddc_pkg;

    localparam int unsigned ECHO_W = 15;
    localparam int unsigned CM_W   = 9;

    localparam logic [14:0] ECHO_MAX_US     = 15'd25000;
    localparam logic [CM_W-1:0] SEEN_LIMIT_CM   = 9'd300;
    localparam logic [CM_W-1:0] FOLLOW_LIMIT_CM = 9'd250;
    localparam logic [CM_W-1:0] SIDE_HIGH_CM    = 9'd120;
    localparam logic [CM_W-1:0] SIDE_LOW_CM     = 9'd5;
    localparam logic [CM_W-1:0] SIDE_RIGHT_CM   = 9'd30;
    localparam logic [CM_W-1:0] SIDE_LEFT_CM    = 9'd60;
    localparam logic [15:0] TURN_MS          = 16'd500;

    // reciprocal of 58, scaled by 2^21; exact for all widths below 2^15
    localparam logic [15:0] RECIP_58 = 16'd36158;

    typedef enum logic [1:0] {
        DIR_OFF = 2'd0,
        DIR_FWD = 2'd1,
        DIR_REV = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        ST_LOST      = 3'd0,
        ST_TOO_CLOSE = 3'd1,
        ST_FOLLOWING = 3'd2,
        ST_HOLDING   = 3'd3,
        ST_NO_ECHO   = 3'd4,
        ST_RIGHT     = 3'd5,
        ST_LEFT      = 3'd6,
        ST_PAUSING   = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_TURNING = 2'd1,
        PH_PAUSING = 2'd2,
        PH_SPARE   = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        REG_TARGET    = 3'd0,
        REG_TOLERANCE = 3'd1,
        REG_MIN_PWM   = 3'd2,
        REG_MAX_PWM   = 3'd3,
        REG_TIMEOUT   = 3'd4,
        REG_GAIN      = 3'd5,
        REG_TURN_PWM  = 3'd6,
        REG_PAUSE     = 3'd7
    } t_reg_idx;

    // distance in cm, zero when the echo is absent or out of range
    function automatic logic [CM_W-1:0] echo_to_cm(input logic [ECHO_W-1:0] us);
        logic [30:0] prod;
        prod = 31'(us) * 31'(RECIP_58);
        if (us == '0 || us > ECHO_MAX_US) begin
            return '0;
        end
        return prod[29:21];
    endfunction

endpackage

### design/follow_distance_drive_controller.sv
`timescale 1ns / 1ps
// Top level of the follow distance drive controller.
// Uses fddc_pkg for codes, limits and the echo to distance conversion.
//
// Input items arrive on the s_axis group: tuser is the kind (0 millisecond tick,
// 1 distance sample), tdata carries the front and side echo widths in microseconds.
// Each item yields at most one result on the m_axis group: motor directions, duty
// and status. A tick gives a result only when a turn ends and the pause begins;
// a sample gives one when no turn sequence is running.
// Echo widths are converted to centimetres as the item is registered; the decision
// logic and one gain multiply sit between that register and the result register.
// Items pass the input, then the result register; one per cycle unless stalled.
// While the result register holds an item that the receiver has not taken, the
// input register holds too and s_axis_tready drops once it is full.
// Configuration writes on the cfg channel are always taken, one per cycle, and must
// happen only while no item is in flight.
// Reset restores the register defaults, clears the counters, stops the motors and
// empties both pipeline registers.
module follow_distance_drive_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [14:0] echo_front_us, [29:15] echo_side_us
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] motor_a_dir, [3:2] motor_b_dir,
                                        // [11:4] drive_pwm, [14:12] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration
    logic [7:0]  r_target, r_tol, r_min_pwm, r_max_pwm, r_gain, r_turn_pwm;
    logic [15:0] r_timeout, r_pause;

    // input register
    logic                      r_in_vld, r_in_sample;
    logic [fddc_pkg::CM_W-1:0] r_front_cm, r_side_cm;

    // state
    logic [15:0]        r_since, n_since;
    fddc_pkg::t_phase   r_phase, n_phase;
    logic [15:0]        r_pc, n_pc;
    fddc_pkg::t_dir     r_a_dir, n_a_dir, r_b_dir, n_b_dir;
    logic [7:0]         r_pwm, n_pwm;

    // result register
    logic                 r_out_vld;
    fddc_pkg::t_status    r_out_status, n_status;
    logic                 n_emit;

    logic        advance;
    logic [15:0] since_inc, pc_inc, since_eff;
    logic        seen;
    logic signed [9:0] near_edge;
    logic [8:0]  far_edge;
    logic [7:0]  err;
    logic [15:0] prod;
    logic [11:0] pwm_raw;
    logic [7:0]  pwm_fwd;

    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_status, r_pwm, r_b_dir, r_a_dir};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= 8'd20;
            r_tol      <= 8'd5;
            r_min_pwm  <= 8'd100;
            r_max_pwm  <= 8'd200;
            r_timeout  <= 16'd3000;
            r_gain     <= 8'd72;
            r_turn_pwm <= 8'd150;
            r_pause    <= 16'd3000;
        end else if (i_cfg_valid) begin
            unique case (fddc_pkg::t_reg_idx'(i_cfg_index))
                fddc_pkg::REG_TARGET:    r_target   <= i_cfg_data[7:0];
                fddc_pkg::REG_TOLERANCE: r_tol      <= i_cfg_data[7:0];
                fddc_pkg::REG_MIN_PWM:   r_min_pwm  <= i_cfg_data[7:0];
                fddc_pkg::REG_MAX_PWM:   r_max_pwm  <= i_cfg_data[7:0];
                fddc_pkg::REG_TIMEOUT:   r_timeout  <= i_cfg_data;
                fddc_pkg::REG_GAIN:      r_gain     <= i_cfg_data[7:0];
                fddc_pkg::REG_TURN_PWM:  r_turn_pwm <= i_cfg_data[7:0];
                fddc_pkg::REG_PAUSE:     r_pause    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_sample <= s_axis_tuser;
            r_front_cm  <= fddc_pkg::echo_to_cm(s_axis_tdata[14:0]);
            r_side_cm   <= fddc_pkg::echo_to_cm(s_axis_tdata[29:15]);
        end
    end

    always_comb begin
        since_inc = (r_since == 16'hFFFF) ? r_since : r_since + 16'd1;
        pc_inc    = (r_pc == 16'hFFFF) ? r_pc : r_pc + 16'd1;
        seen      = (r_front_cm != '0) && (r_front_cm < fddc_pkg::SEEN_LIMIT_CM);
        since_eff = seen ? 16'd0 : r_since;
        near_edge = $signed({2'b00, r_target}) - $signed({2'b00, r_tol});
        far_edge  = {1'b0, r_target} + {1'b0, r_tol};
        err       = r_front_cm[7:0] - r_target;
        prod      = 16'(err) * 16'(r_gain);
        pwm_raw   = prod[15:4];
        if (pwm_raw < 12'(r_min_pwm)) begin
            pwm_fwd = r_min_pwm;
        end else if (pwm_raw > 12'(r_max_pwm)) begin
            pwm_fwd = r_max_pwm;
        end else begin
            pwm_fwd = pwm_raw[7:0];
        end

        n_since  = r_since;
        n_phase  = r_phase;
        n_pc     = r_pc;
        n_a_dir  = r_a_dir;
        n_b_dir  = r_b_dir;
        n_pwm    = r_pwm;
        n_status = fddc_pkg::ST_NO_ECHO;
        n_emit   = 1'b0;

        if (!r_in_sample) begin
            n_since = since_inc;
            if (r_phase == fddc_pkg::PH_TURNING) begin
                n_pc = pc_inc;
                if (pc_inc >= fddc_pkg::TURN_MS) begin
                    n_phase  = fddc_pkg::PH_PAUSING;
                    n_pc     = 16'd0;
                    n_a_dir  = fddc_pkg::DIR_OFF;
                    n_b_dir  = fddc_pkg::DIR_OFF;
                    n_pwm    = 8'd0;
                    n_status = fddc_pkg::ST_PAUSING;
                    n_emit   = 1'b1;
                end
            end else if (r_phase != fddc_pkg::PH_IDLE) begin
                n_pc = pc_inc;
                if (pc_inc >= r_pause) begin
                    n_phase = fddc_pkg::PH_IDLE;
                    n_pc    = 16'd0;
                end
            end
        end else if (r_phase == fddc_pkg::PH_IDLE) begin
            n_since = since_eff;
            n_emit  = 1'b1;
            if (since_eff > r_timeout) begin
                n_a_dir  = fddc_pkg::DIR_OFF;
                n_b_dir  = fddc_pkg::DIR_OFF;
                n_pwm    = 8'd0;
                n_status = fddc_pkg::ST_LOST;
            end else begin
                priority if (r_front_cm != '0
                             && $signed({1'b0, r_front_cm}) < near_edge) begin
                    n_a_dir  = fddc_pkg::DIR_OFF;
                    n_b_dir  = fddc_pkg::DIR_OFF;
                    n_pwm    = 8'd0;
                    n_status = fddc_pkg::ST_TOO_CLOSE;
                end else if (r_front_cm > far_edge
                             && r_front_cm < fddc_pkg::FOLLOW_LIMIT_CM) begin
                    n_a_dir  = fddc_pkg::DIR_FWD;
                    n_b_dir  = fddc_pkg::DIR_FWD;
                    n_pwm    = pwm_fwd;
                    n_status = fddc_pkg::ST_FOLLOWING;
                end else if (r_front_cm != '0) begin
                    n_a_dir  = fddc_pkg::DIR_OFF;
                    n_b_dir  = fddc_pkg::DIR_OFF;
                    n_pwm    = 8'd0;
                    n_status = fddc_pkg::ST_HOLDING;
                end else begin
                    n_status = fddc_pkg::ST_NO_ECHO;
                end
                if (r_side_cm > fddc_pkg::SIDE_LOW_CM
                    && r_side_cm < fddc_pkg::SIDE_HIGH_CM) begin
                    if (r_side_cm < fddc_pkg::SIDE_RIGHT_CM) begin
                        n_a_dir  = fddc_pkg::DIR_FWD;
                        n_b_dir  = fddc_pkg::DIR_REV;
                        n_pwm    = r_turn_pwm;
                        n_phase  = fddc_pkg::PH_TURNING;
                        n_pc     = 16'd0;
                        n_status = fddc_pkg::ST_RIGHT;
                    end else if (r_side_cm > fddc_pkg::SIDE_LEFT_CM) begin
                        n_a_dir  = fddc_pkg::DIR_REV;
                        n_b_dir  = fddc_pkg::DIR_FWD;
                        n_pwm    = r_turn_pwm;
                        n_phase  = fddc_pkg::PH_TURNING;
                        n_pc     = 16'd0;
                        n_status = fddc_pkg::ST_LEFT;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since   <= 16'd0;
            r_phase   <= fddc_pkg::PH_IDLE;
            r_pc      <= 16'd0;
            r_a_dir   <= fddc_pkg::DIR_OFF;
            r_b_dir   <= fddc_pkg::DIR_OFF;
            r_pwm     <= 8'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (advance) begin
                r_since <= n_since;
                r_phase <= n_phase;
                r_pc    <= n_pc;
                r_a_dir <= n_a_dir;
                r_b_dir <= n_b_dir;
                r_pwm   <= n_pwm;
            end
            if (advance) begin
                r_out_vld <= n_emit;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_status <= n_status;
        end
    end

endmodule

### tb/sv/fddc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the follow distance drive controller: watches the item, result and
// register channels, predicts every result from its own copy of the state and compares.
// Depends on fddc_pkg for status, direction, phase and register codes.
module fddc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,
    input  logic        i_in_kind,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int US_PER_CM = 58;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] pwm;
        logic [1:0] b_dir;
        logic [1:0] a_dir;
    } t_drive;

    logic [7:0]  target_cm, tolerance_cm, min_pwm, max_pwm, gain_q4, turn_pwm;
    logic [15:0] lost_ms, pause_ms;
    logic [15:0] since_seen, phase_ms;
    fddc_pkg::t_phase phase;
    fddc_pkg::t_dir   held_a, held_b;
    logic [7:0]  held_pwm;

    t_drive drive_q[$];
    t_drive want, got;
    int     fails = 0;
    int     pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    function automatic int echo_cm(input logic [14:0] us);
        if (us == '0 || us > fddc_pkg::ECHO_MAX_US) begin
            return 0;
        end
        return int'(us) / US_PER_CM;
    endfunction

    function automatic t_drive held_drive(input fddc_pkg::t_status st);
        t_drive d;
        d.a_dir  = held_a;
        d.b_dir  = held_b;
        d.pwm    = held_pwm;
        d.status = st;
        return d;
    endfunction

    task automatic set_drive(input fddc_pkg::t_dir a, input fddc_pkg::t_dir b,
                             input logic [7:0] pwm);
        held_a   = a;
        held_b   = b;
        held_pwm = pwm;
    endtask

    task automatic step_drive(input logic kind, input logic [14:0] front_us,
                              input logic [14:0] side_us);
        int      front_cm, side_cm, near_edge, far_edge, pwm;
        fddc_pkg::t_status st;
        if (kind == 1'b0) begin
            if (since_seen != 16'hFFFF) since_seen++;
            if (phase == fddc_pkg::PH_IDLE) return;
            if (phase_ms != 16'hFFFF) phase_ms++;
            if (phase == fddc_pkg::PH_TURNING) begin
                if (phase_ms >= fddc_pkg::TURN_MS) begin
                    phase    = fddc_pkg::PH_PAUSING;
                    phase_ms = '0;
                    set_drive(fddc_pkg::DIR_OFF, fddc_pkg::DIR_OFF, 8'd0);
                    drive_q.push_back(held_drive(fddc_pkg::ST_PAUSING));
                end
                return;
            end
            if (phase_ms >= pause_ms) begin
                phase    = fddc_pkg::PH_IDLE;
                phase_ms = '0;
            end
            return;
        end
        if (phase != fddc_pkg::PH_IDLE) return;

        front_cm = echo_cm(front_us);
        side_cm  = echo_cm(side_us);
        if (front_cm > 0 && front_cm < int'(fddc_pkg::SEEN_LIMIT_CM)) since_seen = '0;

        if (since_seen > lost_ms) begin
            set_drive(fddc_pkg::DIR_OFF, fddc_pkg::DIR_OFF, 8'd0);
            drive_q.push_back(held_drive(fddc_pkg::ST_LOST));
            return;
        end

        near_edge = int'(target_cm) - int'(tolerance_cm);
        far_edge  = int'(target_cm) + int'(tolerance_cm);
        if (front_cm > 0 && front_cm < near_edge) begin
            set_drive(fddc_pkg::DIR_OFF, fddc_pkg::DIR_OFF, 8'd0);
            st = fddc_pkg::ST_TOO_CLOSE;
        end else if (front_cm > far_edge
                     && front_cm < int'(fddc_pkg::FOLLOW_LIMIT_CM)) begin
            pwm = ((front_cm - int'(target_cm)) * int'(gain_q4)) >>> 4;
            if (pwm < int'(min_pwm)) begin
                pwm = int'(min_pwm);
            end else if (pwm > int'(max_pwm)) begin
                pwm = int'(max_pwm);
            end
            set_drive(fddc_pkg::DIR_FWD, fddc_pkg::DIR_FWD, 8'(pwm));
            st = fddc_pkg::ST_FOLLOWING;
        end else if (front_cm > 0) begin
            set_drive(fddc_pkg::DIR_OFF, fddc_pkg::DIR_OFF, 8'd0);
            st = fddc_pkg::ST_HOLDING;
        end else begin
            st = fddc_pkg::ST_NO_ECHO;
        end

        if (side_cm > int'(fddc_pkg::SIDE_LOW_CM) && side_cm < int'(fddc_pkg::SIDE_HIGH_CM)) begin
            if (side_cm < int'(fddc_pkg::SIDE_RIGHT_CM)) begin
                set_drive(fddc_pkg::DIR_FWD, fddc_pkg::DIR_REV, turn_pwm);
                phase    = fddc_pkg::PH_TURNING;
                phase_ms = '0;
                st       = fddc_pkg::ST_RIGHT;
            end else if (side_cm > int'(fddc_pkg::SIDE_LEFT_CM)) begin
                set_drive(fddc_pkg::DIR_REV, fddc_pkg::DIR_FWD, turn_pwm);
                phase    = fddc_pkg::PH_TURNING;
                phase_ms = '0;
                st       = fddc_pkg::ST_LEFT;
            end
        end
        drive_q.push_back(held_drive(st));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            target_cm    = 8'd20;
            tolerance_cm = 8'd5;
            min_pwm      = 8'd100;
            max_pwm      = 8'd200;
            lost_ms      = 16'd3000;
            gain_q4      = 8'd72;
            turn_pwm     = 8'd150;
            pause_ms     = 16'd3000;
            since_seen   = '0;
            phase_ms     = '0;
            phase        = fddc_pkg::PH_IDLE;
            set_drive(fddc_pkg::DIR_OFF, fddc_pkg::DIR_OFF, 8'd0);
            drive_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[14:0];
                if (drive_q.size() == 0) begin
                    $error("result %h with nothing expected", i_out_data);
                    fails++;
                end else begin
                    want = drive_q.pop_front();
                    if (got.a_dir != want.a_dir) begin
                        $error("motor_a_dir expected %0d got %0d", want.a_dir, got.a_dir);
                        fails++;
                    end
                    if (got.b_dir != want.b_dir) begin
                        $error("motor_b_dir expected %0d got %0d", want.b_dir, got.b_dir);
                        fails++;
                    end
                    if (got.pwm != want.pwm) begin
                        $error("drive_pwm expected %0d got %0d", want.pwm, got.pwm);
                        fails++;
                    end
                    if (got.status != want.status) begin
                        $error("status expected %0d got %0d", want.status, got.status);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (fddc_pkg::t_reg_idx'(i_cfg_index))
                    fddc_pkg::REG_TARGET:    target_cm    = i_cfg_data[7:0];
                    fddc_pkg::REG_TOLERANCE: tolerance_cm = i_cfg_data[7:0];
                    fddc_pkg::REG_MIN_PWM:   min_pwm      = i_cfg_data[7:0];
                    fddc_pkg::REG_MAX_PWM:   max_pwm      = i_cfg_data[7:0];
                    fddc_pkg::REG_TIMEOUT:   lost_ms      = i_cfg_data;
                    fddc_pkg::REG_GAIN:      gain_q4      = i_cfg_data[7:0];
                    fddc_pkg::REG_TURN_PWM:  turn_pwm     = i_cfg_data[7:0];
                    fddc_pkg::REG_PAUSE:     pause_ms     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                step_drive(i_in_kind, i_in_data[14:0], i_in_data[29:15]);
            end
        end
        pending = drive_q.size();
    end

endmodule

### tb/sv/follow_distance_drive_controller_tb.sv
`timescale 1ns / 1ps
// Testbench top for the follow distance drive controller: clock, reset, stimulus and verdict.
// Needs fddc_pkg, the block and fddc_checker, which predicts and compares the results.
module follow_distance_drive_controller_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    int mismatches;
    int outstanding;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    int cur_target = 20;
    int cur_tol = 5;
    int cur_pause = 3000;

    follow_distance_drive_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    fddc_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_kind    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (mismatches),
        .o_pending    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stalls per item, one long hold-off on request
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req      = 1'b0;
                m_axis_tready = 1'b0;
                repeat (60) @(negedge i_clk);
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 5);
                if (stall != 0) begin
                    m_axis_tready = 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    task automatic send_item(input logic kind, input logic [14:0] front_us,
                             input logic [14:0] side_us);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  = kind;
        s_axis_tdata  = {2'b00, side_us, front_us};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic tick();
        send_item(1'b0, 15'($urandom), 15'($urandom));
    endtask

    task automatic sample(input logic [14:0] front_us, input logic [14:0] side_us);
        send_item(1'b1, front_us, side_us);
    endtask

    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input fddc_pkg::t_reg_idx idx, input logic [15:0] value);
        i_cfg_index = idx;
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(input int tgt, input int tol, input int lo_pwm, input int hi_pwm,
                             input int tmo, input int gain, input int tpwm, input int pause);
        settle();
        write_reg(fddc_pkg::REG_TARGET,    {8'($urandom), 8'(tgt)});
        write_reg(fddc_pkg::REG_TOLERANCE, {8'($urandom), 8'(tol)});
        write_reg(fddc_pkg::REG_MIN_PWM,   {8'($urandom), 8'(lo_pwm)});
        write_reg(fddc_pkg::REG_MAX_PWM,   {8'($urandom), 8'(hi_pwm)});
        write_reg(fddc_pkg::REG_TIMEOUT,   16'(tmo));
        write_reg(fddc_pkg::REG_GAIN,      {8'($urandom), 8'(gain)});
        write_reg(fddc_pkg::REG_TURN_PWM,  {8'($urandom), 8'(tpwm)});
        write_reg(fddc_pkg::REG_PAUSE,     16'(pause));
        cur_target = tgt;
        cur_tol    = tol;
        cur_pause  = pause;
    endtask

    function automatic logic [14:0] echo_at(input int cm);
        int us;
        if (cm < 0) cm = 0;
        us = cm * 58 + int'($urandom_range(0, 57));
        if (us > 25000) us = 25000;
        return 15'(us);
    endfunction

    function automatic logic [14:0] front_pick();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 15'($urandom_range(25001, 32767));
            2: return 15'($urandom);
            3, 4, 5: return echo_at(cur_target - cur_tol - 4
                                    + int'($urandom_range(0, 2 * cur_tol + 8)));
            default: return echo_at(int'($urandom_range(0, 440)));
        endcase
    endfunction

    function automatic logic [14:0] side_calm();
        logic [14:0] raw;
        int          cm;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return echo_at(int'($urandom_range(0, 5)));
            2: return echo_at(int'($urandom_range(30, 60)));
            3: return echo_at(int'($urandom_range(120, 440)));
            4: return 15'($urandom_range(25001, 32767));
            default: begin
                raw = 15'($urandom);
                cm  = int'(raw) / 58;
                if (raw <= 15'd25000 && cm > 5 && cm < 120 && (cm < 30 || cm > 60)) begin
                    raw[14] = 1'b1;
                end
                return raw;
            end
        endcase
    endfunction

    function automatic logic [14:0] side_turn();
        if ($urandom_range(0, 1) == 0) return echo_at(int'($urandom_range(6, 29)));
        return echo_at(int'($urandom_range(61, 119)));
    endfunction

    // carry a turn and its pause to the end, with stray samples that must be dropped
    task automatic turn_run(input int ticks);
        repeat (ticks) begin
            if ($urandom_range(0, 49) == 0) sample(front_pick(), side_calm());
            tick();
        end
    endtask

    initial begin
        int ph;
        int roll;
        int drain;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        tick();
        sample(15'd0, 15'd0);
        sample(15'd25001, 15'd0);
        sample(15'h7FFF, 15'h7FFF);
        sample(15'd57, 15'd0);
        sample(15'd58, 15'd0);
        sample(15'd1160, 15'd0);
        sample(15'd1508, 15'd0);
        sample(15'd14442, 15'd0);
        sample(15'd14500, 15'd0);
        sample(15'd17399, 15'd0);
        sample(15'd17400, 15'd0);
        sample(15'd25000, 15'd25000);
        sample(15'd2900, 15'd0);
        sample(15'd0, 15'd0);
        sample(15'd1160, 15'd290);
        sample(15'd1160, 15'd6960);
        sample(15'd1160, 15'd1740);
        sample(15'd1160, 15'd3537);
        settle();
        write_reg(fddc_pkg::REG_PAUSE, 16'd4);
        cur_pause = 4;
        sample(15'd1160, 15'd348);
        turn_run(500 + 4 + 2);
        sample(15'd0, 15'd0);
        sample(15'd1160, 15'd0);

        for (ph = 0; ph < 6; ph++) begin
            if (ph == 0) begin
                configure(0, 0, 0, 255, 65535, 255, 0, 0);
            end else if (ph == 1) begin
                configure(255, 255, 255, 0, 0, 0, 255, 1);
            end else begin
                configure(($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
                                                      : int'($urandom_range(10, 120)),
                          int'($urandom_range(0, 30)),
                          int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                          ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 40))
                                                      : int'($urandom_range(0, 65535)),
                          int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                          ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 30)));
            end
            no_idle = (ph % 3 == 2);
            if (ph == 3) begin
                sample(echo_at(100), side_turn());
                turn_run(500 + cur_pause + 2);
            end
            if (ph == 4) begin
                hold_req = 1'b1;
                repeat (8) sample(front_pick(), side_calm());
            end
            repeat (50) begin
                roll = $urandom_range(0, 999);
                if (roll < 300) begin
                    tick();
                end else begin
                    sample(front_pick(), side_calm());
                end
            end
        end

        no_idle = 1'b1;
        configure(30, 5, 80, 220, 65535, 64, 200, 0);
        sample(15'd0, echo_at(119));
        turn_run(500 + 2);
        sample(15'd0, 15'd0);
        sample(echo_at(100), 15'd0);
        no_idle = 1'b0;

        s_axis_tvalid = 1'b0;
        drain = 0;
        while (outstanding != 0 && drain < 5000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (10) @(negedge i_clk);
        if (outstanding != 0) $error("%0d results never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
design/fddc_pkg.sv
design/follow_distance_drive_controller.sv
tb/sv/fddc_checker.sv
tb/sv/follow_distance_drive_controller_tb.sv
